// ----- rtl/core/hnca_pkg.sv -----
package hnca_pkg;

  localparam int MAX_CENTERS = 64;
  localparam int MAX_POINTS  = 4096;
  localparam int DESC_WORDS  = 4;

  localparam int CW = $clog2(MAX_CENTERS);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int WW = $clog2(DESC_WORDS);

  localparam logic [8:0]    DIST_CAP  = 9'd256;
  localparam logic [8:0]    DIST_NONE = 9'd257;
  localparam logic [12:0]   COUNT_MAX = 13'd8191;
  localparam logic [CW-1:0] CENT_LAST = CW'(MAX_CENTERS - 1);
  localparam logic [6:0]    IN_USE_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SEED  = 2'd1,
    CMD_BEGIN = 2'd2,
    CMD_WORD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEED,
    S_BEGIN,
    S_WORD,
    S_DECIDE,
    S_BUMP
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] point_index;
    logic [5:0]  center_index;
    logic [1:0]  word_index;
    logic [63:0] data;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  chosen_center;
    logic [8:0]  best_distance;
    logic        moved;
    logic [12:0] move_count;
  } out_item_t;

  // per-center state carried along the ring
  typedef struct packed {
    logic        ne;
    logic [8:0]  pdist;
    logic [12:0] pop;
  } cell_t;

endpackage

// ----- rtl/core/hnca_cell.sv -----
module hnca_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  hnca_pkg::cell_t din,
  output hnca_pkg::cell_t dout
);

  hnca_pkg::cell_t q;

  // take the neighbour's entry on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= din;
    end
  end

  assign dout = q;

endmodule

// ----- rtl/core/hamming_nearest_center_assign_unit.sv -----
// channel   | direction | handshake           | beat
// item      | in        | start & !busy       | in_item_t
// result    | out       | result_valid        | out_item_t (one cycle, no stall)
// config    | in        | cfg_we              | cfg_wdata = centers_in_use
//
// Load center word: taken on accept. Seed and begin pass: one ring
// rotation of the 64 center cells. Point word: 64 center reads from the
// center memory, one per cycle, plus two pipeline stages; a last word
// adds a decide state and a population rotation of the ring.
// After reset a clearing pass sweeps the point memory; busy stays high
// through it. Results cannot be held off by the receiver.
module hamming_nearest_center_assign_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  hnca_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata,
  output logic                 result_valid,
  output hnca_pkg::out_item_t  result
);

  hnca_pkg::state_t state, state_next;
  hnca_pkg::in_item_t it;
  hnca_pkg::cell_t chain [hnca_pkg::MAX_CENTERS];
  hnca_pkg::cell_t head_new;

  logic [6:0]                 in_use;
  logic [6:0]                 n_act;
  logic [hnca_pkg::CW-1:0]    cnt;
  logic                       iss;
  logic                       s1_v, s2_v;
  logic [hnca_pkg::CW-1:0]    s1_k, s2_k, hk;
  logic [6:0]                 pc;
  logic [63:0]                cmem_q;
  logic [63:0]                cmem [hnca_pkg::MAX_CENTERS*hnca_pkg::DESC_WORDS];
  logic [hnca_pkg::CW:0]      pm_q;
  logic [hnca_pkg::CW:0]      pmem [hnca_pkg::MAX_POINTS];
  logic [hnca_pkg::PW-1:0]    clr_cnt;
  logic                       pm_we;
  logic [hnca_pkg::PW-1:0]    pm_wa;
  logic [hnca_pkg::CW:0]      pm_wd;
  logic [8:0]                 best, cand;
  logic [hnca_pkg::CW-1:0]    win;
  logic [12:0]                pass_moves;
  logic                       rot, accept, head_used, moved;
  logic [9:0]                 sum;
  logic [8:0]                 nd;
  logic [12:0]                p;

  assign accept = start && !busy;

  // clamp centers in use to 1..MAX_CENTERS
  always_comb begin
    n_act = in_use;
    if (in_use == 7'd0) n_act = 7'd1;
    if (in_use > 7'(hnca_pkg::MAX_CENTERS)) n_act = 7'(hnca_pkg::MAX_CENTERS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= hnca_pkg::IN_USE_RST;
    end else if (cfg_we) begin
      in_use <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hnca_pkg::S_CLEAR:
        if (clr_cnt == '1) state_next = hnca_pkg::S_IDLE;
      hnca_pkg::S_IDLE:
        if (start) begin
          unique case (item.cmd)
            hnca_pkg::CMD_SEED:  state_next = hnca_pkg::S_SEED;
            hnca_pkg::CMD_BEGIN: state_next = hnca_pkg::S_BEGIN;
            hnca_pkg::CMD_WORD:  state_next = hnca_pkg::S_WORD;
            default:             state_next = hnca_pkg::S_IDLE;
          endcase
        end
      hnca_pkg::S_SEED, hnca_pkg::S_BEGIN, hnca_pkg::S_BUMP:
        if (cnt == hnca_pkg::CENT_LAST) state_next = hnca_pkg::S_IDLE;
      hnca_pkg::S_WORD:
        if (s2_v && s2_k == hnca_pkg::CENT_LAST)
          state_next = it.last_word ? hnca_pkg::S_DECIDE : hnca_pkg::S_IDLE;
      hnca_pkg::S_DECIDE:
        state_next = hnca_pkg::S_BUMP;
      default:
        state_next = hnca_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hnca_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer
  always_comb begin
    busy  = 1'b1;
    rot   = 1'b0;
    pm_we = 1'b0;
    pm_wa = clr_cnt;
    pm_wd = '0;
    hk    = cnt;
    unique case (state)
      hnca_pkg::S_CLEAR: pm_we = 1'b1;
      hnca_pkg::S_IDLE:  busy = 1'b0;
      hnca_pkg::S_SEED: begin
        rot   = 1'b1;
        pm_we = (cnt == '0);
        pm_wa = it.point_index;
        pm_wd = {1'b1, it.center_index};
      end
      hnca_pkg::S_BEGIN, hnca_pkg::S_BUMP: rot = 1'b1;
      hnca_pkg::S_WORD: begin
        rot = s2_v;
        hk  = s2_k;
      end
      hnca_pkg::S_DECIDE: begin
        pm_we = 1'b1;
        pm_wa = it.point_index;
        pm_wd = {1'b1, win};
      end
      default: busy = 1'b1;
    endcase
  end

  // counters, item capture and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      cnt     <= '0;
      iss     <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
    end else begin
      if (state == hnca_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == hnca_pkg::S_IDLE || state == hnca_pkg::S_DECIDE) begin
        cnt <= '0;
      end else if (rot && state != hnca_pkg::S_WORD) begin
        cnt <= cnt + 1'b1;
      end else if (state == hnca_pkg::S_WORD && iss) begin
        cnt <= cnt + 1'b1;
      end
      if (accept && item.cmd == hnca_pkg::CMD_WORD) begin
        iss <= 1'b1;
      end else if (iss && cnt == hnca_pkg::CENT_LAST) begin
        iss <= 1'b0;
      end
      s1_v <= (state == hnca_pkg::S_WORD) && iss;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) it <= item;
    s1_k <= cnt;
    s2_k <= s1_k;
    pc   <= 7'($countones(it.data ^ cmem_q));
  end

  // center memory: write on load, read one center word per cycle
  always_ff @(posedge clk) begin
    if (accept && item.cmd == hnca_pkg::CMD_LOAD)
      cmem[{item.center_index, item.word_index}] <= item.data;
    cmem_q <= cmem[{cnt, it.word_index}];
  end

  // point memory: valid bit and assignment, read at accept
  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_wa] <= pm_wd;
    if (accept) pm_q <= pmem[item.point_index];
  end

  // ring of center cells
  genvar g;
  generate
    for (g = 0; g < hnca_pkg::MAX_CENTERS; g++) begin : g_cell
      if (g == hnca_pkg::MAX_CENTERS - 1) begin : g_tail
        hnca_cell u_cell (.clk, .rst, .shift(rot), .din(head_new), .dout(chain[g]));
      end else begin : g_mid
        hnca_cell u_cell (.clk, .rst, .shift(rot), .din(chain[g+1]), .dout(chain[g]));
      end
    end
  endgenerate

  // update the entry leaving the head of the ring
  always_comb begin
    head_new  = chain[0];
    head_used = ({1'b0, hk} < n_act);
    sum       = {1'b0, chain[0].pdist} + (head_used ? {3'b0, pc} : 10'd0);
    nd        = (sum > {1'b0, hnca_pkg::DIST_CAP}) ? hnca_pkg::DIST_CAP : sum[8:0];
    cand      = chain[0].ne ? nd : hnca_pkg::DIST_NONE;
    p         = chain[0].pop;
    case (state)
      hnca_pkg::S_SEED: begin
        if (pm_q[hnca_pkg::CW] && pm_q[hnca_pkg::CW-1:0] == hk && p != '0) p = p - 1'b1;
        if (hk == it.center_index && p != hnca_pkg::COUNT_MAX) p = p + 1'b1;
        head_new.pop = p;
      end
      hnca_pkg::S_BEGIN: begin
        head_new.ne    = (chain[0].pop != '0);
        head_new.pop   = '0;
        head_new.pdist = '0;
      end
      hnca_pkg::S_BUMP: begin
        if (hk == win && p != hnca_pkg::COUNT_MAX) head_new.pop = p + 1'b1;
      end
      hnca_pkg::S_WORD: head_new.pdist = it.last_word ? 9'd0 : nd;
      default: head_new = chain[0];
    endcase
  end

  // strict minimum scan, lowest index first
  always_ff @(posedge clk) begin
    if (state == hnca_pkg::S_WORD && s2_v && it.last_word) begin
      if (s2_k == '0) begin
        best <= cand;
        win  <= '0;
      end else if (head_used && cand < best) begin
        best <= cand;
        win  <= s2_k;
      end
    end
  end

  assign moved = !pm_q[hnca_pkg::CW] || (pm_q[hnca_pkg::CW-1:0] != win);

  // move counter and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_moves   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (accept && item.cmd == hnca_pkg::CMD_BEGIN) begin
        pass_moves   <= '0;
        result_valid <= 1'b1;
        result       <= '{kind: 1'b1, chosen_center: '0, best_distance: '0,
                          moved: 1'b0, move_count: pass_moves};
      end else if (state == hnca_pkg::S_DECIDE) begin
        result_valid <= 1'b1;
        result.kind          <= 1'b0;
        result.chosen_center <= win;
        result.best_distance <= best;
        result.moved         <= moved;
        if (moved && pass_moves != hnca_pkg::COUNT_MAX) begin
          pass_moves        <= pass_moves + 1'b1;
          result.move_count <= pass_moves + 1'b1;
        end else begin
          result.move_count <= pass_moves;
        end
      end
    end
  end

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == hnca_pkg::S_DECIDE) ||
                     ($past(accept) && $past(item.cmd) == hnca_pkg::CMD_BEGIN))
    else $error("result beat without a source");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.best_distance <= hnca_pkg::DIST_NONE)
    else $error("distance out of range");

  a_summary: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind |-> result.chosen_center == '0 && !result.moved)
    else $error("summary beat carries point fields");

  a_pipe: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> state == hnca_pkg::S_WORD)
    else $error("distance beat outside word state");

endmodule

// ----- dv/tb_hamming_nearest_center_assign_unit.sv -----
module tb_hamming_nearest_center_assign_unit;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  hnca_pkg::in_item_t  item = '0;
  logic                cfg_we = 1'b0;
  logic [6:0]          cfg_wdata = '0;
  logic                result_valid;
  hnca_pkg::out_item_t result;

  // per-center and per-point model state
  class assign_scoreboard;
    logic [63:0] center_word [hnca_pkg::MAX_CENTERS*hnca_pkg::DESC_WORDS];
    bit          was_nonempty [hnca_pkg::MAX_CENTERS];
    int unsigned population [hnca_pkg::MAX_CENTERS];
    logic [5:0]  owner [hnca_pkg::MAX_POINTS];
    bit          owned [hnca_pkg::MAX_POINTS];
    int unsigned partial [hnca_pkg::MAX_CENTERS];
    int unsigned pass_moves;
    int unsigned in_use;
    hnca_pkg::out_item_t pending_q[$];
    int          errors;
    int          matched;

    function new();
      foreach (center_word[i]) center_word[i] = '0;
      foreach (was_nonempty[i]) begin
        was_nonempty[i] = 0;
        population[i] = 0;
        partial[i] = 0;
      end
      foreach (owned[i]) begin
        owned[i] = 0;
        owner[i] = '0;
      end
      pass_moves = 0;
      in_use = {25'd0, hnca_pkg::IN_USE_RST};
      errors = 0;
      matched = 0;
    endfunction

    function void set_in_use(logic [6:0] v);
      in_use = {25'd0, v};
    endfunction

    function void note_item(hnca_pkg::in_item_t it);
      hnca_pkg::out_item_t r;
      int unsigned n, best, d, win;
      bit mv;
      r = '0;
      case (hnca_pkg::cmd_t'(it.cmd))
        hnca_pkg::CMD_LOAD: begin
          center_word[it.center_index*hnca_pkg::DESC_WORDS + it.word_index] = it.data;
        end
        hnca_pkg::CMD_SEED: begin
          if (owned[it.point_index] && population[owner[it.point_index]] > 0)
            population[owner[it.point_index]]--;
          owner[it.point_index] = it.center_index;
          owned[it.point_index] = 1;
          if (population[it.center_index] < hnca_pkg::COUNT_MAX)
            population[it.center_index]++;
        end
        hnca_pkg::CMD_BEGIN: begin
          for (int c = 0; c < hnca_pkg::MAX_CENTERS; c++) begin
            was_nonempty[c] = population[c] != 0;
            population[c] = 0;
            partial[c] = 0;
          end
          r.kind = 1'b1;
          r.move_count = pass_moves[12:0];
          pass_moves = 0;
          pending_q.push_back(r);
        end
        default: begin
          n = (in_use < 1) ? 1 :
              (in_use > hnca_pkg::MAX_CENTERS ? hnca_pkg::MAX_CENTERS : in_use);
          for (int c = 0; c < n; c++) begin
            d = partial[c] + $countones(it.data ^
                center_word[c*hnca_pkg::DESC_WORDS + it.word_index]);
            partial[c] = (d > hnca_pkg::DIST_CAP) ? hnca_pkg::DIST_CAP : d;
          end
          if (it.last_word) begin
            best = was_nonempty[0] ? partial[0] : hnca_pkg::DIST_NONE;
            win = 0;
            for (int c = 1; c < n; c++) begin
              d = was_nonempty[c] ? partial[c] : hnca_pkg::DIST_NONE;
              if (d < best) begin
                best = d;
                win = c;
              end
            end
            if (population[win] < hnca_pkg::COUNT_MAX) population[win]++;
            mv = !owned[it.point_index] || owner[it.point_index] != win;
            owner[it.point_index] = 6'(win);
            owned[it.point_index] = 1;
            if (mv && pass_moves < hnca_pkg::COUNT_MAX) pass_moves++;
            for (int c = 0; c < hnca_pkg::MAX_CENTERS; c++) partial[c] = 0;
            r.chosen_center = 6'(win);
            r.best_distance = 9'(best);
            r.moved = mv;
            r.move_count = pass_moves[12:0];
            pending_q.push_back(r);
          end
        end
      endcase
    endfunction

    function void check_result(hnca_pkg::out_item_t got);
      hnca_pkg::out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      matched++;
      if (got.kind !== exp_r.kind) begin
        $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
      end
      if (got.chosen_center !== exp_r.chosen_center) begin
        $error("chosen_center exp %0d got %0d", exp_r.chosen_center, got.chosen_center);
        errors++;
      end
      if (got.best_distance !== exp_r.best_distance) begin
        $error("best_distance exp %0d got %0d", exp_r.best_distance, got.best_distance);
        errors++;
      end
      if (got.moved !== exp_r.moved) begin
        $error("moved exp %0d got %0d", exp_r.moved, got.moved); errors++;
      end
      if (got.move_count !== exp_r.move_count) begin
        $error("move_count exp %0d got %0d", exp_r.move_count, got.move_count); errors++;
      end
    endfunction
  endclass

  assign_scoreboard sb;
  int sent;
  int burst_left;

  hamming_nearest_center_assign_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .result(result)
  );

  always #6 clk = ~clk;

  // accept beats and check results on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(item);
      if (result_valid) sb.check_result(result);
    end
  end

  // hold one item until accepted, with random gaps between bursts
  task automatic send_item(hnca_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_in_use(logic [6:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_in_use(v);
  endtask

  function automatic hnca_pkg::in_item_t mk(hnca_pkg::cmd_t c, logic [11:0] p,
                                            logic [5:0] ce, logic [1:0] w,
                                            logic [63:0] d, logic l);
    hnca_pkg::in_item_t it;
    it.cmd = c; it.point_index = p; it.center_index = ce;
    it.word_index = w; it.data = d; it.last_word = l;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // load every word of every center so no unwritten entry is read
  task automatic load_all_centers();
    for (int c = 0; c < hnca_pkg::MAX_CENTERS; c++)
      for (int w = 0; w < hnca_pkg::DESC_WORDS; w++)
        send_item(mk(hnca_pkg::CMD_LOAD, 12'($urandom), 6'(c), 2'(w), rand64(),
                     1'($urandom)));
  endtask

  // stream one point; all four words in order, or fewer words at random indices, some missing or repeated
  task automatic send_point(logic [11:0] p);
    int nw;
    nw = $urandom_range(1, 4);
    for (int i = 0; i < nw; i++)
      send_item(mk(hnca_pkg::CMD_WORD, p, 6'($urandom),
                   (nw == 4) ? 2'(i) : 2'($urandom), rand64(), i == nw - 1));
  endtask

  initial begin
    int k;
    sb = new();
    sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: load centers, seed, begin, extremes and all-empty case
    load_all_centers();
    send_item(mk(hnca_pkg::CMD_WORD, 12'd0, 6'd0, 2'd0, '0, 1'b1));
    send_item(mk(hnca_pkg::CMD_WORD, 12'hFFF, 6'h3F, 2'd3, '1, 1'b1));
    send_item(mk(hnca_pkg::CMD_BEGIN, '0, '0, '0, '0, 1'b0));
    send_item(mk(hnca_pkg::CMD_SEED, 12'd0, 6'd0, 2'd0, '0, 1'b0));
    send_item(mk(hnca_pkg::CMD_SEED, 12'hFFF, 6'h3F, 2'd3, '1, 1'b1));
    send_item(mk(hnca_pkg::CMD_SEED, 12'd5, 6'd3, 2'd0, '0, 1'b0));
    send_item(mk(hnca_pkg::CMD_SEED, 12'd5, 6'd7, 2'd0, '0, 1'b0));
    send_item(mk(hnca_pkg::CMD_BEGIN, '0, '0, '0, '0, 1'b0));
    send_item(mk(hnca_pkg::CMD_WORD, 12'd5, 6'd0, 2'd0, '1, 1'b0));
    send_item(mk(hnca_pkg::CMD_WORD, 12'd5, 6'd0, 2'd1, '0, 1'b0));
    send_item(mk(hnca_pkg::CMD_WORD, 12'd5, 6'd0, 2'd2, '1, 1'b0));
    send_item(mk(hnca_pkg::CMD_WORD, 12'd5, 6'd0, 2'd3, '0, 1'b1));
    send_item(mk(hnca_pkg::CMD_WORD, 12'hFFF, 6'd0, 2'd0, '1, 1'b1));
    send_item(mk(hnca_pkg::CMD_BEGIN, '0, '0, '0, '0, 1'b0));

    // random phases over several centre counts, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_in_use(7'd1);
        1: write_in_use(7'd0);
        2: write_in_use(7'd127);
        3: write_in_use(7'd64);
        4: write_in_use(7'($urandom_range(2, 63)));
        default: write_in_use(7'd2);
      endcase
      k = 0;
      while (k < 15) begin
        case ($urandom_range(0, 9))
          0: send_item(mk(hnca_pkg::CMD_LOAD, 12'($urandom), 6'($urandom), 2'($urandom),
                          rand64(), 1'($urandom)));
          1, 2: send_item(mk(hnca_pkg::CMD_SEED, 12'($urandom_range(0, 31)), 6'($urandom),
                             2'($urandom), rand64(), 1'($urandom)));
          3: send_item(mk(hnca_pkg::CMD_BEGIN, 12'($urandom), 6'($urandom), 2'($urandom),
                          rand64(), 1'($urandom)));
          default: send_point($urandom_range(0, 3) == 0 ? 12'($urandom)
                              : 12'($urandom_range(0, 31)));
        endcase
        k++;
      end
      // hold off until every pending result is in
      drain();
    end
    drain();
    $display("Sent %0d items over six centre-count settings; %0d results checked.",
             sent, sb.matched);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("FAIL");
    $finish;
  end

endmodule
